/* sv/adbh_pkg.sv */
// Shared types and constants for the averaged deadband heater stepper.
// No dependencies; imported by every module of the block.
package adbh_pkg;

  // Averaging window: number of samples held in the cell chain
  localparam int AVERAGE_DEPTH = 8;

  localparam int SAMPLE_W  = 8;
  localparam int SUM_W     = $clog2(AVERAGE_DEPTH * 255 + 1);
  localparam int OUT_SUM_W = 11;
  localparam int LEVEL_W   = 8;
  localparam int TEMP_W    = 8;
  localparam int MV_W      = 16;
  localparam int SETP_W    = 8;
  localparam int BAND_W    = 4;

  // Average = sum / AVERAGE_DEPTH via reciprocal multiply, exact for any SUM_W-bit sum
  localparam int AVG_K = SUM_W + $clog2(AVERAGE_DEPTH);
  localparam int AVG_M = (2 ** AVG_K + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH;
  localparam int AVG_M_W = AVG_K + 1;

  // Conversion constants
  localparam int MV_SCALE  = 194;
  localparam int F_DIVISOR = 30;
  localparam int F_OFFSET  = 32;
  localparam int F_X_W     = MV_W - 3;
  localparam int F_K       = F_X_W + $clog2(F_DIVISOR);
  localparam int F_M       = (2 ** F_K + F_DIVISOR - 1) / F_DIVISOR;
  localparam int F_M_W     = F_K + 1;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
  localparam logic [SETP_W-1:0]  SETPOINT_RESET = 8'd127;
  localparam logic [BAND_W-1:0]  DEADBAND_RESET = 4'd2;

  // Register map, selected by address bit 2
  localparam logic REG_SETPOINT = 1'b0;
  localparam logic REG_DEADBAND = 1'b1;

  // Setpoint and band handed to the drive-level cell
  typedef struct packed {
    logic [SETP_W-1:0] setpoint;
    logic [BAND_W-1:0] band;
  } cfg_t;

endpackage

/* sv/adbh_cell.sv */
// One sample cell of the averaging chain: holds a sample and passes it on.
// Depends on adbh_pkg.
module adbh_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift,
  input  logic [adbh_pkg::SAMPLE_W-1:0] d,
  output logic [adbh_pkg::SAMPLE_W-1:0] q
);
  import adbh_pkg::*;

  logic [SAMPLE_W-1:0] q_r;

  // Chain starts all zero so early averages count empty cells as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

/* sv/adbh_duty.sv */
// Heater drive level with deadband stepping and saturation.
// Depends on adbh_pkg.
module adbh_duty (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic [adbh_pkg::TEMP_W-1:0]  temp_f,
  input  adbh_pkg::cfg_t               cfg,
  output logic [adbh_pkg::LEVEL_W-1:0] level
);
  import adbh_pkg::*;

  logic [LEVEL_W-1:0] level_r, level_nxt, raised;
  logic [TEMP_W:0]    f_plus_band, sp_plus_band;
  logic               raise, lower;

  // Raise test first, then lower test, each saturating
  always_comb begin
    f_plus_band  = {1'b0, temp_f} + {{(TEMP_W + 1 - BAND_W){1'b0}}, cfg.band};
    sp_plus_band = {1'b0, cfg.setpoint} + {{(TEMP_W + 1 - BAND_W){1'b0}}, cfg.band};
    raise = ({1'b0, cfg.setpoint} >= f_plus_band);
    lower = (sp_plus_band <= {1'b0, temp_f});
    raised = (raise && level_r != LEVEL_MAX) ? level_r + 1'b1 : level_r;
    level_nxt = (lower && raised != '0) ? raised - 1'b1 : raised;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LEVEL_MAX;
    end else if (load) begin
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule

/* sv/averaged_deadband_heater_stepper.sv */
// Averaged deadband heater stepper: top level with sample chain and pipeline.
// Depends on adbh_pkg, adbh_cell and adbh_duty.
//
// Input channel (in_valid/in_stall) carries one 8-bit converter sample per
// transaction. Each sample shifts into a chain of AVERAGE_DEPTH cells; the
// sample leaving the chain is subtracted from the running sum as the new one
// is added. Output channel (out_valid/out_stall) carries one result per
// sample: drive level, degrees F, sum and scaled millivolts.
// A result reaches out_valid through five register stages (sum at the
// accepting edge, average multiply, millivolt multiply, divide-by-30
// multiply, drive-level update). Throughput: one transaction per cycle while
// the receiver does not stall; the running-sum and drive-level updates are
// the per-sample loops. When the receiver stalls, results queue in the
// pipeline stages and in_stall rises once every stage is occupied.
// Reset (rst_n, synchronous) clears the chain and sum to zero, sets the
// drive level to 255, setpoint to 127 and dead band to 2; no clearing pass.
// Registers over APB: setpoint at 0x0, dead band at 0x4 (address bit 2
// selects); write only while the pipeline is empty.
module averaged_deadband_heater_stepper (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [adbh_pkg::SAMPLE_W-1:0]  in_adc_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [adbh_pkg::LEVEL_W-1:0]   out_drive_level,
  output logic [adbh_pkg::TEMP_W-1:0]    out_temperature_f,
  output logic [adbh_pkg::OUT_SUM_W-1:0] out_sample_sum,
  output logic [adbh_pkg::MV_W-1:0]      out_scaled_millivolts,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import adbh_pkg::*;

  // Configuration registers
  cfg_t cfg_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint <= SETPOINT_RESET;
      cfg_r.band     <= DEADBAND_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SETPOINT) begin
        cfg_r.setpoint <= pwdata[SETP_W-1:0];
      end else begin
        cfg_r.band <= pwdata[BAND_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_DEADBAND) begin
      prdata = {{(32 - BAND_W){1'b0}}, cfg_r.band};
    end else begin
      prdata = {{(32 - SETP_W){1'b0}}, cfg_r.setpoint};
    end
  end

  // Pipeline occupancy and flow control
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, accept;

  assign rdy5     = !out_valid_r || !out_stall;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) out_valid_r <= v4_r;
    end
  end

  // Sample cell chain; the last cell holds the sample AVERAGE_DEPTH transactions old
  logic [SAMPLE_W-1:0] chain_q [AVERAGE_DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < AVERAGE_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        adbh_cell u_cell (
          .clk   (clk),
          .rst_n (rst_n),
          .shift (accept),
          .d     (in_adc_sample),
          .q     (chain_q[gi])
        );
      end else begin : g_body
        adbh_cell u_cell (
          .clk   (clk),
          .rst_n (rst_n),
          .shift (accept),
          .d     (chain_q[gi-1]),
          .q     (chain_q[gi])
        );
      end
    end
  endgenerate

  // Stage 1: running sum (also the stage register)
  logic [SUM_W-1:0] sum_r, sum_nxt;

  assign sum_nxt = sum_r - {{(SUM_W - SAMPLE_W){1'b0}}, chain_q[AVERAGE_DEPTH-1]}
                 + {{(SUM_W - SAMPLE_W){1'b0}}, in_adc_sample};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (accept) begin
      sum_r <= sum_nxt;
    end
  end

  // Stage 2: average by reciprocal multiply
  logic [SUM_W+AVG_M_W-1:0] avg_prod;
  logic [SAMPLE_W-1:0]      avg2_r;
  logic [OUT_SUM_W-1:0]     sum2_r;

  assign avg_prod = {{AVG_M_W{1'b0}}, sum_r} * AVG_M[AVG_M_W-1:0];

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      avg2_r <= avg_prod[AVG_K +: SAMPLE_W];
      sum2_r <= OUT_SUM_W'(sum_r);
    end
  end

  // Stage 3: scaled millivolts
  logic [MV_W-1:0]      mv3_r;
  logic [OUT_SUM_W-1:0] sum3_r;

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      mv3_r  <= {{(MV_W - SAMPLE_W){1'b0}}, avg2_r} * MV_W'(MV_SCALE);
      sum3_r <= sum2_r;
    end
  end

  // Stage 4: degrees F = (mv >> 3) / 30 + 32, divide by reciprocal multiply
  logic [F_X_W+F_M_W-1:0] f_prod;
  logic [TEMP_W-1:0]      temp4_r;
  logic [MV_W-1:0]        mv4_r;
  logic [OUT_SUM_W-1:0]   sum4_r;

  assign f_prod = {{F_M_W{1'b0}}, mv3_r[MV_W-1:3]} * F_M[F_M_W-1:0];

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      temp4_r <= f_prod[F_K +: TEMP_W] + TEMP_W'(F_OFFSET);
      mv4_r   <= mv3_r;
      sum4_r  <= sum3_r;
    end
  end

  // Stage 5: drive level update and output register
  logic                 out_load;
  logic [TEMP_W-1:0]    temp5_r;
  logic [MV_W-1:0]      mv5_r;
  logic [OUT_SUM_W-1:0] sum5_r;
  logic [LEVEL_W-1:0]   level;

  assign out_load = rdy5 && v4_r;

  adbh_duty u_duty (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (out_load),
    .temp_f (temp4_r),
    .cfg    (cfg_r),
    .level  (level)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      temp5_r <= temp4_r;
      mv5_r   <= mv4_r;
      sum5_r  <= sum4_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_drive_level       = level;
  assign out_temperature_f     = temp5_r;
  assign out_sample_sum        = sum5_r;
  assign out_scaled_millivolts = mv5_r;

  // Checks
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= SUM_W'(AVERAGE_DEPTH * 255))
    else $error("running sum exceeds window maximum");

  a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(out_drive_level))
    else $error("drive level changed without a result load");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v4_r))
    else $error("result appeared without a stage 4 transaction");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> !in_stall)
    else $error("input stalled with first stage empty");

endmodule
